// ----- rtl/cdb_pkg.sv -----
// ----------------------------------------------------------------------------
// cdb_pkg
// Shared operation codes, status codes and the access control type of the
// circular deque buffer.
// ----------------------------------------------------------------------------
package cdb_pkg;

   // Operation carried by a request.
   typedef enum logic [2:0] {
      MODE_PUSH_HEAD  = 3'd0,
      MODE_PUSH_TAIL  = 3'd1,
      MODE_POP_HEAD   = 3'd2,
      MODE_POP_TAIL   = 3'd3,
      MODE_READ_INDEX = 3'd4,
      MODE_WRITE_INDEX = 3'd5
   } mode_type;

   // Status returned with every response.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // Decision of the control logic for one request.
   typedef struct packed {
      status_type status;
      logic       we;
      logic       re;
   } access_type;

endpackage

// ----- rtl/cdb_ram.sv -----
// ----------------------------------------------------------------------------
// cdb_ram
// Generic single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module cdb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One access per cycle: a write or a read of one entry.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/cdb_ctrl.sv -----
// ----------------------------------------------------------------------------
// cdb_ctrl
// Request decoder: checks full, empty and index range, resolves the entry
// address and produces the next head, tail and count values.
// ----------------------------------------------------------------------------
module cdb_ctrl #(
   parameter int DEPTH = 64
) (
   input  logic [2:0]                     req_mode,
   input  logic signed [6:0]              req_index,
   input  logic [$clog2(DEPTH)-1:0]       head,
   input  logic [$clog2(DEPTH)-1:0]       tail,
   input  logic [$clog2(DEPTH+1)-1:0]     count,
   output logic [$clog2(DEPTH)-1:0]       addr,
   output logic [$clog2(DEPTH)-1:0]       head_in,
   output logic [$clog2(DEPTH)-1:0]       tail_in,
   output logic [$clog2(DEPTH+1)-1:0]     count_in,
   output cdb_pkg::access_type            access
);
   import cdb_pkg::*;

   localparam int PW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > 7) ? CW : 7;
   localparam int AW   = ((PW > 7) ? PW : 7) + 2;

   logic [PW-1:0]   head_inc, head_dec, tail_inc, tail_dec;
   logic            full, empty;
   logic            neg;
   logic [6:0]      back;
   logic [CMPW-1:0] cnt_cmp;
   logic            in_range;
   logic [AW-1:0]   pos_sum, neg_sum, raw_slot, slot;

   // Ring pointer steps, wrapping at the capacity.
   assign head_inc = (head == PW'(DEPTH - 1)) ? '0 : head + PW'(1);
   assign head_dec = (head == '0) ? PW'(DEPTH - 1) : head - PW'(1);
   assign tail_inc = (tail == PW'(DEPTH - 1)) ? '0 : tail + PW'(1);
   assign tail_dec = (tail == '0) ? PW'(DEPTH - 1) : tail - PW'(1);

   assign full  = (count == CW'(DEPTH));
   assign empty = (count == '0);

   // A negative index counts back from the head, a non-negative one from the tail.
   assign neg     = req_index[6];
   assign back    = 7'(~req_index) + 7'd1;
   assign cnt_cmp = CMPW'(count);
   assign in_range = neg ? (CMPW'(back) <= cnt_cmp)
                         : (CMPW'(req_index[5:0]) < cnt_cmp);

   // Both sums stay below twice the capacity when in range: one subtract wraps.
   assign pos_sum  = AW'(tail) + AW'(req_index[5:0]);
   assign neg_sum  = AW'(head) + AW'(DEPTH) - AW'(back);
   assign raw_slot = neg ? neg_sum : pos_sum;
   assign slot     = (raw_slot >= AW'(DEPTH)) ? raw_slot - AW'(DEPTH) : raw_slot;

   // Per-operation decision; errors leave the state as it is.
   always_comb begin
      access.status = ST_OK;
      access.we     = 1'b0;
      access.re     = 1'b0;
      addr          = '0;
      head_in       = head;
      tail_in       = tail;
      count_in      = count;
      case (mode_type'(req_mode))
         MODE_PUSH_HEAD: begin
            if (full) begin
               access.status = ST_FULL;
            end else begin
               access.we = 1'b1;
               addr      = head;
               head_in   = head_inc;
               count_in  = count + CW'(1);
            end
         end
         MODE_PUSH_TAIL: begin
            if (full) begin
               access.status = ST_FULL;
            end else begin
               access.we = 1'b1;
               addr      = tail_dec;
               tail_in   = tail_dec;
               count_in  = count + CW'(1);
            end
         end
         MODE_POP_HEAD: begin
            if (empty) begin
               access.status = ST_EMPTY;
            end else begin
               access.re = 1'b1;
               addr      = head_dec;
               head_in   = head_dec;
               count_in  = count - CW'(1);
            end
         end
         MODE_POP_TAIL: begin
            if (empty) begin
               access.status = ST_EMPTY;
            end else begin
               access.re = 1'b1;
               addr      = tail;
               tail_in   = tail_inc;
               count_in  = count - CW'(1);
            end
         end
         MODE_READ_INDEX: begin
            if (in_range) begin
               access.re = 1'b1;
               addr      = slot[PW-1:0];
            end else begin
               access.status = ST_RANGE;
            end
         end
         MODE_WRITE_INDEX: begin
            if (in_range) begin
               access.we = 1'b1;
               addr      = slot[PW-1:0];
            end else begin
               access.status = ST_RANGE;
            end
         end
         default: begin
            // Unused codes do nothing.
         end
      endcase
   end

endmodule

// ----- rtl/circular_deque_buffer_top.sv -----
// ----------------------------------------------------------------------------
// circular_deque_buffer_top
// Fixed-capacity double-ended ring buffer with indexed read and write.
//
//   channel   direction  ports                                handshake
//   request   in         req_mode, req_value, req_index       start && !busy
//   response  out        rsp_data, rsp_status, rsp_count      rsp_valid strobe
//
// One request per cycle while busy is low; its response follows on the next cycle.
// The decoder addresses the element RAM straight from the request, so the
// RAM's registered read sets the response delay, not the rate.
// A write lands at the accept edge, before the next request reads.
// Reset clears the pointers and count; busy is high for one cycle after it.
// The receiver cannot stall: every response is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module circular_deque_buffer_top #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [2:0]             req_mode,
   input  logic [31:0]            req_value,
   input  logic signed [6:0]      req_index,
   output logic                   rsp_valid,
   output logic [31:0]            rsp_data,
   output cdb_pkg::status_type    rsp_status,
   output logic [6:0]             rsp_count
);
   import cdb_pkg::*;

   localparam int PW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > 7) ? CW : 7;
   localparam int XW   = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

   logic [PW-1:0]         head_ff, tail_ff, head_in, tail_in, addr;
   logic [CW-1:0]         count_ff, count_in;
   logic [CMPW-1:0]       count_ext;
   access_type            access;
   logic                  accept;
   logic                  busy_ff;
   logic                  rsp_valid_ff, rd_sel_ff;
   status_type            status_ff;
   logic [6:0]            rsp_count_ff;
   logic [XW-1:0]         val_ext, rd_ext;
   logic [DATA_WIDTH-1:0] ram_rdata;

   assign accept = start && !busy_ff;

   // Decode the request against the current pointers.
   cdb_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .req_mode  (req_mode),
      .req_index (req_index),
      .head      (head_ff),
      .tail      (tail_ff),
      .count     (count_ff),
      .addr      (addr),
      .head_in   (head_in),
      .tail_in   (tail_in),
      .count_in  (count_in),
      .access    (access)
   );

   // Element store; data is masked to the element width on the way in.
   assign val_ext = XW'(req_value);

   cdb_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (accept && access.we),
      .re    (accept && access.re),
      .addr  (addr),
      .wdata (val_ext[DATA_WIDTH-1:0]),
      .rdata (ram_rdata)
   );

   assign count_ext = CMPW'(count_in);

   // Pointer state and the registered response fields.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
         rd_sel_ff    <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= accept;
         if (accept) begin
            head_ff   <= head_in;
            tail_ff   <= tail_in;
            count_ff  <= count_in;
            rd_sel_ff <= access.re;
         end
      end
      if (accept) begin
         status_ff    <= access.status;
         rsp_count_ff <= count_ext[6:0];
      end
   end

   // Read data comes straight from the RAM output register.
   assign rd_ext     = XW'(ram_rdata);
   assign busy       = busy_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rd_sel_ff ? rd_ext[31:0] : 32'd0;
   assign rsp_status = status_ff;
   assign rsp_count  = rsp_count_ff;

   // Every accepted request yields exactly one response on the next cycle.
   a_one_response: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff == $past(accept))
      else $error("response strobe does not follow the request");

   // The stored element count never exceeds the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("element count above capacity");

   // A full refusal leaves the buffer full, an empty refusal leaves it empty.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == ST_FULL) |-> count_ff == CW'(DEPTH))
      else $error("full status with buffer not full");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == ST_EMPTY) |-> count_ff == '0)
      else $error("empty status with buffer not empty");

   // An error never carries element data.
   a_error_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff != ST_OK) |-> !rd_sel_ff)
      else $error("data returned with an error status");

endmodule

// ----- tb/deque_response_checker.sv -----
// ----------------------------------------------------------------------------
// deque_response_checker
// Watches the request and response channels of the circular deque buffer.
// Every accepted request is applied to a private copy of the ring (store,
// head and tail pointers, element count), and the response it should cause
// is queued. Each response strobe is compared field by field with the oldest
// queued response. The failure count and the number of responses still owed
// are handed to the testbench top.
// ----------------------------------------------------------------------------
module deque_response_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [2:0]          req_mode,
   input  logic [31:0]         req_value,
   input  logic signed [6:0]   req_index,
   input  logic                rsp_valid,
   input  logic [31:0]         rsp_data,
   input  cdb_pkg::status_type rsp_status,
   input  logic [6:0]          rsp_count,
   output int                  failures,
   output int                  pending,
   output int                  checked
);
   import cdb_pkg::*;

   localparam int DEPTH = 64;
   localparam int PTR_W = $clog2(DEPTH);

   typedef struct {
      logic [31:0] data;
      status_type  status;
      logic [6:0]  count;
   } deque_response_type;

   // Private copy of the ring.
   logic [31:0]      ring_slots [DEPTH];
   logic [PTR_W-1:0] head_ptr = '0;
   logic [PTR_W-1:0] tail_ptr = '0;
   logic [6:0]       level    = '0;

   deque_response_type owed_responses [$];
   deque_response_type oldest;
   int                 error_total = 0;
   int                 compared    = 0;

   // Map a signed index onto a ring slot. Non-negative indexes count up from
   // the tail, negative ones count back from the head.
   function automatic bit resolve_slot(input logic signed [6:0] idx,
                                       output logic [PTR_W-1:0] slot);
      int back;
      slot = '0;
      if (idx < 0) begin
         back = -int'(idx);
         if (back > int'(level)) return 1'b0;
         slot = head_ptr - PTR_W'(back);
      end else begin
         if (int'(idx) >= int'(level)) return 1'b0;
         slot = tail_ptr + idx[PTR_W-1:0];
      end
      return 1'b1;
   endfunction

   // Apply one request to the ring and return the response it causes.
   function automatic deque_response_type apply_request(input logic [2:0]        mode,
                                                        input logic [31:0]       value,
                                                        input logic signed [6:0] idx);
      deque_response_type r;
      logic [PTR_W-1:0]   slot;
      r.data   = '0;
      r.status = ST_OK;
      case (mode)
         MODE_PUSH_HEAD: begin
            if (level >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               ring_slots[head_ptr] = value;
               head_ptr = head_ptr + 1'b1;
               level    = level + 1'b1;
            end
         end
         MODE_PUSH_TAIL: begin
            if (level >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               tail_ptr = tail_ptr - 1'b1;
               ring_slots[tail_ptr] = value;
               level    = level + 1'b1;
            end
         end
         MODE_POP_HEAD: begin
            if (level == 0) begin
               r.status = ST_EMPTY;
            end else begin
               head_ptr = head_ptr - 1'b1;
               r.data   = ring_slots[head_ptr];
               level    = level - 1'b1;
            end
         end
         MODE_POP_TAIL: begin
            if (level == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.data   = ring_slots[tail_ptr];
               tail_ptr = tail_ptr + 1'b1;
               level    = level - 1'b1;
            end
         end
         MODE_READ_INDEX: begin
            if (resolve_slot(idx, slot)) r.data = ring_slots[slot];
            else r.status = ST_RANGE;
         end
         MODE_WRITE_INDEX: begin
            if (resolve_slot(idx, slot)) ring_slots[slot] = value;
            else r.status = ST_RANGE;
         end
         default: begin
            // Spare modes change nothing.
         end
      endcase
      r.count = level;
      return r;
   endfunction

   // Compare the response of this edge first, then queue the one owed for a
   // request accepted at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         head_ptr = '0;
         tail_ptr = '0;
         level    = '0;
         owed_responses.delete();
      end else begin
         if (rsp_valid) begin
            if (owed_responses.size() == 0) begin
               $error("response strobe with no request outstanding");
               error_total++;
            end else begin
               oldest = owed_responses.pop_front();
               compared++;
               if (rsp_data !== oldest.data) begin
                  $error("rsp_data: expected %h, actual %h", oldest.data, rsp_data);
                  error_total++;
               end
               if (rsp_status !== oldest.status) begin
                  $error("rsp_status: expected %0d, actual %0d", oldest.status, rsp_status);
                  error_total++;
               end
               if (rsp_count !== oldest.count) begin
                  $error("rsp_count: expected %0d, actual %0d", oldest.count, rsp_count);
                  error_total++;
               end
            end
         end
         if (start && !busy) begin
            owed_responses = {owed_responses,
                              apply_request(req_mode, req_value, req_index)};
         end
      end
      failures <= error_total;
      pending  <= owed_responses.size();
      checked  <= compared;
   end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives requests into the circular deque buffer and gives the verdict.
// A short directed sequence covers empty-buffer errors, both push and pop
// ends, index extremes and the spare modes. Random traffic then runs in
// fill, drain and balanced phases so that the buffer reaches full and empty
// repeatedly, with random gaps between requests. Checking is done by the
// response checker instantiated beside the buffer.
// ----------------------------------------------------------------------------
module testbench;
   import cdb_pkg::*;

   localparam int CAPACITY     = 64;
   localparam int ITEM_TOTAL   = 1000;
   localparam int PHASE_LEN    = 160;
   localparam int DRAIN_CYCLES = 4;
   localparam int CYCLE_LIMIT  = 200000;

   // Mode codes that the buffer treats as no operation.
   localparam logic [2:0] MODE_SPARE_LO = 3'd6;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              start     = 1'b0;
   logic [2:0]        req_mode  = '0;
   logic [31:0]       req_value = '0;
   logic signed [6:0] req_index = '0;
   logic              busy;
   logic              rsp_valid;
   logic [31:0]       rsp_data;
   status_type        rsp_status;
   logic [6:0]        rsp_count;

   int failures;
   int pending;
   int checked;
   int cycles      = 0;
   int fill_level  = 0;
   int peak_level  = 0;
   int full_pushes = 0;
   int empty_pops  = 0;
   bit idle_on     = 1'b1;

   always #10 clock = ~clock;

   circular_deque_buffer_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_mode   (req_mode),
      .req_value  (req_value),
      .req_index  (req_index),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count)
   );

   deque_response_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_mode   (req_mode),
      .req_value  (req_value),
      .req_index  (req_index),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count),
      .failures   (failures),
      .pending    (pending),
      .checked    (checked)
   );

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[circular_deque_buffer_top] ERROR");
         $finish;
      end
   end

   // Present one request after an optional gap and hold it until accepted.
   // Called and left at a falling edge.
   task automatic issue(input logic [2:0] mode, input logic [31:0] value,
                        input logic signed [6:0] idx);
      int gap;
      gap = idle_on ? $urandom_range(0, 15) : 0;
      repeat (gap) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start     <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      req_index <= idx;
      do @(posedge clock); while (busy);
      @(negedge clock);
      // Track occupancy only to steer the random traffic.
      case (mode)
         MODE_PUSH_HEAD, MODE_PUSH_TAIL: begin
            if (fill_level == CAPACITY) full_pushes++;
            else fill_level++;
         end
         MODE_POP_HEAD, MODE_POP_TAIL: begin
            if (fill_level == 0) empty_pops++;
            else fill_level--;
         end
         default: begin
         end
      endcase
      if (fill_level > peak_level) peak_level = fill_level;
   endtask

   // Mostly an index that selects a stored element, sometimes any index.
   function automatic logic signed [6:0] pick_index();
      if (fill_level > 0 && $urandom_range(0, 4) != 0) begin
         if ($urandom_range(0, 1) == 1) return 7'($urandom_range(0, fill_level - 1));
         return -7'($urandom_range(1, fill_level));
      end
      return 7'($urandom());
   endfunction

   initial begin
      int          phase;
      int          pick;
      int          push_pct;
      int          pop_pct;
      logic [2:0]  mode;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty buffer: every pop and every index is refused.
      issue(MODE_POP_HEAD, 32'h1234_5678, 7'sd0);
      issue(MODE_POP_TAIL, 32'h0, 7'sd0);
      issue(MODE_READ_INDEX, 32'h0, 7'sd0);
      issue(MODE_WRITE_INDEX, 32'hDEAD_BEEF, -7'sd1);
      issue(MODE_READ_INDEX, 32'h0, -7'sd64);

      // Push onto both ends with extreme data.
      issue(MODE_PUSH_HEAD, 32'hFFFF_FFFF, 7'sd0);
      issue(MODE_PUSH_TAIL, 32'h0000_0000, 7'sd0);
      issue(MODE_PUSH_HEAD, 32'hA5A5_A5A5, 7'sd63);
      issue(MODE_PUSH_TAIL, 32'h5A5A_5A5A, -7'sd64);

      // Index reads at and just past both range limits.
      issue(MODE_READ_INDEX, 32'h0, 7'sd0);
      issue(MODE_READ_INDEX, 32'h0, 7'sd3);
      issue(MODE_READ_INDEX, 32'h0, 7'sd4);
      issue(MODE_READ_INDEX, 32'h0, -7'sd1);
      issue(MODE_READ_INDEX, 32'h0, -7'sd4);
      issue(MODE_READ_INDEX, 32'h0, -7'sd5);
      issue(MODE_READ_INDEX, 32'h0, 7'sd63);
      issue(MODE_READ_INDEX, 32'h0, -7'sd64);

      // Indexed writes from either end, read one back, then an out-of-range write.
      issue(MODE_WRITE_INDEX, 32'hC3C3_3C3C, 7'sd1);
      issue(MODE_WRITE_INDEX, 32'h8000_0001, -7'sd2);
      issue(MODE_READ_INDEX, 32'h0, 7'sd1);
      issue(MODE_WRITE_INDEX, 32'h7FFF_FFFE, 7'sd5);

      // Spare modes and one pop from each end.
      issue(MODE_SPARE_LO, 32'hFFFF_FFFF, -7'sd1);
      issue(MODE_SPARE_HI, 32'hFFFF_FFFF, 7'sd63);
      issue(MODE_POP_HEAD, 32'h0, 7'sd0);
      issue(MODE_POP_TAIL, 32'h0, 7'sd0);

      // Random traffic in fill, drain and balanced phases.
      for (int n = 0; n < ITEM_TOTAL; n++) begin
         phase = (n / PHASE_LEN) % 3;
         if (n % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
         push_pct = (phase == 0) ? 60 : (phase == 1) ? 10 : 30;
         pop_pct  = (phase == 0) ? 10 : (phase == 1) ? 60 : 30;
         pick     = $urandom_range(0, 99);
         if (pick < push_pct)
            mode = ($urandom_range(0, 1) == 1) ? MODE_PUSH_HEAD : MODE_PUSH_TAIL;
         else if (pick < push_pct + pop_pct)
            mode = ($urandom_range(0, 1) == 1) ? MODE_POP_HEAD : MODE_POP_TAIL;
         else if (pick < 96)
            mode = ($urandom_range(0, 1) == 1) ? MODE_READ_INDEX : MODE_WRITE_INDEX;
         else
            mode = ($urandom_range(0, 1) == 1) ? MODE_SPARE_LO : MODE_SPARE_HI;
         issue(mode, $urandom(), pick_index());
      end
      start <= 1'b0;

      // Let every owed response arrive, then idle before the verdict.
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d responses; peak occupancy %0d of %0d entries.",
               checked, peak_level, CAPACITY);
      $display("Pushes into a full buffer: %0d; pops from an empty buffer: %0d.",
               full_pushes, empty_pops);
      if (failures == 0) begin
         $display("[circular_deque_buffer_top] OK");
      end else begin
         $display("[circular_deque_buffer_top] ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/cdb_pkg.sv
rtl/cdb_ram.sv
rtl/cdb_ctrl.sv
rtl/circular_deque_buffer_top.sv
tb/deque_response_checker.sv
tb/testbench.sv
